@@ sv/rsf_pkg.sv @@
// Shared constants, result type and kernel arithmetic for the RGB sharpen filter.
`timescale 1ns / 1ps

package rsf_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CHAN_W     = 8;
    localparam int PIX_W      = 3 * CHAN_W;
    localparam int LINE_W     = 2 * PIX_W;
    localparam int ROW_W      = 12;
    localparam int COL_W      = 11;
    localparam int CFG_W      = 12;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } res_t;

    // 5*centre - up - down - left - right, clamped to 0..255
    function automatic logic [CHAN_W-1:0] sharpen_chan(
        input logic [CHAN_W-1:0] ctr,
        input logic [CHAN_W-1:0] up,
        input logic [CHAN_W-1:0] dn,
        input logic [CHAN_W-1:0] lf,
        input logic [CHAN_W-1:0] rt
    );
        logic signed [11:0] c12;
        logic signed [11:0] v;
        logic [CHAN_W-1:0]  res;
        c12 = $signed({4'b0, ctr});
        v = (c12 <<< 2) + c12
            - $signed({4'b0, up}) - $signed({4'b0, dn})
            - $signed({4'b0, lf}) - $signed({4'b0, rt});
        if (v < 12'sd0)
        begin
            res = '0;
        end
        else if (v > 12'sd255)
        begin
            res = 8'd255;
        end
        else
        begin
            res = v[CHAN_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] sharpen_px(
        input logic [PIX_W-1:0] ctr,
        input logic [PIX_W-1:0] up,
        input logic [PIX_W-1:0] dn,
        input logic [PIX_W-1:0] lf,
        input logic [PIX_W-1:0] rt
    );
        logic [PIX_W-1:0] res;
        for (int k = 0; k < 3; k++)
        begin
            res[k*CHAN_W +: CHAN_W] = sharpen_chan(ctr[k*CHAN_W +: CHAN_W],
                up[k*CHAN_W +: CHAN_W], dn[k*CHAN_W +: CHAN_W],
                lf[k*CHAN_W +: CHAN_W], rt[k*CHAN_W +: CHAN_W]);
        end
        return res;
    endfunction

endpackage

@@ sv/rsf_ram.sv @@
// Simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module rsf_ram #(
    parameter int DEPTH = 2048,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ sv/rsf_fifo.sv @@
// Result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps

module rsf_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [1:0]                     push_cnt,
    input  rsf_pkg::res_t                  push_d0,
    input  rsf_pkg::res_t                  push_d1,
    input  logic                           pop,
    output rsf_pkg::res_t                  head,
    output logic                           head_valid,
    output logic [rsf_pkg::FIFO_CNT_W-1:0] count
);
    import rsf_pkg::*;

    res_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wptr_reg;
    logic [FIFO_PTR_W-1:0] wptr_next;
    logic [FIFO_PTR_W-1:0] rptr_reg;
    logic [FIFO_PTR_W-1:0] rptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic                  do_pop;

    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rptr_reg];
    assign count      = cnt_reg;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wptr_next = wptr_reg + FIFO_PTR_W'(push_cnt);
        rptr_next = rptr_reg + FIFO_PTR_W'(do_pop);
        cnt_next  = cnt_reg + FIFO_CNT_W'(push_cnt) - FIFO_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem_reg[wptr_reg] <= push_d0;
        end
        if (push_cnt == 2'd2)
        begin
            mem_reg[wptr_reg + FIFO_PTR_W'(1)] <= push_d1;
        end
    end

endmodule

@@ sv/rgb_sharpen_filter.sv @@
// Top level: streaming 3x3 sharpen filter on RGB888 pixels with two line stores.
`timescale 1ns / 1ps

// Accepts one pixel per clock while in_ready is high, in raster order, and
// sharpens every pixel at least two pixels inside each image edge (5*centre
// minus the four direct neighbours, clamped to 0..255); all other pixels pass
// through unchanged. Both line stores share one 48-bit RAM read at acceptance
// and written back the next cycle, with forwarding when the same column is hit
// twice in a row. A pixel enters the result queue the cycle after its transfer
// and can leave on the next edge. A sharpened pixel comes out when its
// lower-right neighbour arrives, so one input can give zero, one or two
// results; results leave at one per clock while out_ready is high, also near
// image borders. in_ready is low unless the result queue has room for two
// results of the pixel in flight and two of a new one. The user writes
// image_width and image_height only while the block is idle (not enforced).
module rgb_sharpen_filter (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rsf_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    in_red,
    input  logic [7:0]                    in_green,
    input  logic [7:0]                    in_blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    out_red,
    output logic [7:0]                    out_green,
    output logic [7:0]                    out_blue,
    output logic [11:0]                   out_row,
    output logic [10:0]                   out_col,
    output logic                          last_of_run
);
    import rsf_pkg::*;

    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;

    logic              s1_valid_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic              s1_sharp_reg;
    logic              s1_border_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [PIX_W-1:0]  win_up_reg;
    logic [PIX_W-1:0]  win_ctr_reg;
    logic [PIX_W-1:0]  win_dn_reg;
    logic [PIX_W-1:0]  win_left_reg;

    logic [CFG_W-1:0]  w_eff;
    logic [CFG_W-1:0]  h_eff;
    logic [12:0]       c13;
    logic [12:0]       r13;
    logic [12:0]       w13;
    logic [12:0]       h13;
    logic              accept;
    logic              sharp;
    logic              border;
    logic [PIX_W-1:0]  in_px;

    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_eff;
    logic [PIX_W-1:0]  eff_prev2;
    logic [PIX_W-1:0]  eff_prev;
    logic [PIX_W-1:0]  sharp_px;

    res_t              sharp_res;
    res_t              border_res;
    res_t              push_d0;
    logic [1:0]        push_cnt;
    res_t              head;
    logic [FIFO_CNT_W-1:0] fifo_cnt;
    logic [FIFO_CNT_W-1:0] need;

    assign in_px  = {in_red, in_green, in_blue};
    assign need   = fifo_cnt + FIFO_CNT_W'({s1_valid_reg, 1'b0});
    assign in_ready = (need <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign accept = in_valid && in_ready;

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = CFG_W'(1);
        end
        else if (width_reg > CFG_W'(MAX_WIDTH))
        begin
            w_eff = CFG_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        h_eff = (height_reg == '0) ? CFG_W'(1) : height_reg;

        c13 = {2'b0, col_reg};
        r13 = {1'b0, row_reg};
        w13 = {1'b0, w_eff};
        h13 = {1'b0, h_eff};

        sharp  = (r13 >= 13'd3) && (r13 + 13'd2 <= h13)
              && (c13 >= 13'd3) && (c13 + 13'd2 <= w13);
        border = (r13 < 13'd2) || (r13 + 13'd2 >= h13)
              || (c13 < 13'd2) || (c13 + 13'd2 >= w13);

        if (c13 + 13'd1 >= w13)
        begin
            col_next = '0;
            row_next = (r13 + 13'd1 >= h13) ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                row_reg <= row_next;
                col_reg <= col_next;
                fwd_reg <= s1_valid_reg && (s1_idx_reg == col_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_idx_reg    <= col_reg;
            s1_px_reg     <= in_px;
            s1_sharp_reg  <= sharp;
            s1_border_reg <= border;
            s1_row_reg    <= row_reg;
            s1_col_reg    <= col_reg;
            fwd_data_reg  <= {eff_prev, s1_px_reg};
        end
    end

    rsf_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (LINE_W)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_idx_reg),
        .wr_data ({eff_prev, s1_px_reg})
    );

    assign line_eff  = fwd_reg ? fwd_data_reg : ram_rd_data;
    assign eff_prev2 = line_eff[LINE_W-1:PIX_W];
    assign eff_prev  = line_eff[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_up_reg   <= '0;
            win_ctr_reg  <= '0;
            win_dn_reg   <= '0;
            win_left_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            win_left_reg <= win_ctr_reg;
            win_up_reg   <= eff_prev2;
            win_ctr_reg  <= eff_prev;
            win_dn_reg   <= s1_px_reg;
        end
    end

    assign sharp_px = sharpen_px(win_ctr_reg, win_up_reg, win_dn_reg, win_left_reg, eff_prev);

    always_comb
    begin
        sharp_res.red    = sharp_px[23:16];
        sharp_res.green  = sharp_px[15:8];
        sharp_res.blue   = sharp_px[7:0];
        sharp_res.row    = s1_row_reg - ROW_W'(1);
        sharp_res.col    = s1_col_reg - COL_W'(1);
        sharp_res.last   = !s1_border_reg;

        border_res.red   = s1_px_reg[23:16];
        border_res.green = s1_px_reg[15:8];
        border_res.blue  = s1_px_reg[7:0];
        border_res.row   = s1_row_reg;
        border_res.col   = s1_col_reg;
        border_res.last  = 1'b1;

        push_d0 = s1_sharp_reg ? sharp_res : border_res;
        if (s1_valid_reg)
        begin
            push_cnt = 2'(s1_sharp_reg) + 2'(s1_border_reg);
        end
        else
        begin
            push_cnt = 2'd0;
        end
    end

    rsf_fifo u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push_d0    (push_d0),
        .push_d1    (border_res),
        .pop        (out_ready),
        .head       (head),
        .head_valid (out_valid),
        .count      (fifo_cnt)
    );

    assign out_red     = head.red;
    assign out_green   = head.green;
    assign out_blue    = head.blue;
    assign out_row     = head.row;
    assign out_col     = head.col;
    assign last_of_run = head.last;

    a_s1_from_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> $past(in_valid && in_ready))
        else $error("stage 1 active without an input transfer");

    a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_reg && s1_valid_reg && $past(accept) |-> $past(s1_valid_reg))
        else $error("line store forward without a preceding item");

    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (fifo_cnt <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue lacks room for stage 1 results");

    a_two_results_sharp: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt == 2'd2 |-> s1_sharp_reg && s1_border_reg)
        else $error("two results pushed without sharpened and border pixel");

endmodule
